// ----- design/dirty_tile_tracker_assert.svh -----
// Assertion macros for the dirty tile tracker checker.
// Needs clk and rst in the scope where the macros are used.
`ifndef DIRTY_TILE_TRACKER_ASSERT_SVH
`define DIRTY_TILE_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/dtt_pkg.sv -----
// Shared widths, codes and reset values for the dirty tile tracker.
// No dependencies; used by the interfaces, the top level and the checker.
package dtt_pkg;

  localparam int COL_W    = 7;
  localparam int ROW_W    = 6;
  localparam int TILE_W   = 8;
  localparam int OFFS_W   = COL_W + ROW_W;
  localparam int CODE_W   = 16;
  localparam int CMD_W    = 2;
  localparam int PEND_W   = 2;
  localparam int VCOLS_W  = 8;
  localparam int VROWS_W  = 7;

  // Map geometry: the offset is row and column side by side.
  localparam int MAP_COLS  = 1 << COL_W;
  localparam int MAP_ROWS  = 1 << ROW_W;
  localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;

  localparam int DIRTY_ENTRIES_DEF = 16;

  localparam logic [PEND_W-1:0] BOTH_BUFFERS = 2'b11;

  localparam int PATCH_CNT_W = 5;
  localparam logic [PATCH_CNT_W-1:0] MAX_PATCHES = 5'd16;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_APPLY = 2'd2;

  // Register file
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CHAR_BASE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_COLS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_ROWS = 2'd2;

  localparam logic [CODE_W-1:0]  CHAR_BASE_RST = 16'd928;
  localparam logic [VCOLS_W-1:0] VIEW_COLS_RST = 8'd41;
  localparam logic [VROWS_W-1:0] VIEW_ROWS_RST = 7'd26;

endpackage

// ----- design/dtt_if.sv -----
// Valid/ready channel interfaces for the command words and the result words.
// Depends on dtt_pkg.
interface dtt_in_if;
  logic                           valid;
  logic                           ready;
  logic [dtt_pkg::CMD_W-1:0]      cmd;
  logic [dtt_pkg::COL_W-1:0]      tile_x;
  logic [dtt_pkg::ROW_W-1:0]      tile_y;
  logic [dtt_pkg::TILE_W-1:0]     tile_value;
  logic                           buffer_sel;
  logic                           full_rebuild;
  logic [dtt_pkg::COL_W-1:0]      view_origin_x;
  logic [dtt_pkg::ROW_W-1:0]      view_origin_y;
  logic                           wrap_mode;

  modport source (
    output valid, cmd, tile_x, tile_y, tile_value, buffer_sel, full_rebuild,
           view_origin_x, view_origin_y, wrap_mode,
    input  ready
  );
  modport sink (
    input  valid, cmd, tile_x, tile_y, tile_value, buffer_sel, full_rebuild,
           view_origin_x, view_origin_y, wrap_mode,
    output ready
  );
endinterface

interface dtt_out_if;
  logic                           valid;
  logic                           ready;
  logic                           changed;
  logic                           table_overflow;
  logic [dtt_pkg::OFFS_W-1:0]     map_offset;
  logic [dtt_pkg::CODE_W-1:0]     char_code;
  logic                           patch_valid;
  logic [dtt_pkg::COL_W-1:0]      patch_col;
  logic [dtt_pkg::ROW_W-1:0]      patch_row;
  logic                           last;

  modport source (
    output valid, changed, table_overflow, map_offset, char_code, patch_valid,
           patch_col, patch_row, last,
    input  ready
  );
  modport sink (
    input  valid, changed, table_overflow, map_offset, char_code, patch_valid,
           patch_col, patch_row, last,
    output ready
  );
endinterface

// ----- design/dirty_tile_tracker.sv -----
// Dirty tile tracker: a 128 x 64 tile map in a single-port-read RAM plus a table of
// dirty tiles walked by a small sequencer (one entry per cycle in a mark's search).
// After reset the map is cleared one cell a cycle, all 8192 cells, and no command word
// is taken until that is done (register writes are taken throughout). A load writes
// the map when taken. A mark compares the tile with the map and, if it changed,
// searches the table up to the fill count and adds it if absent. An apply checks each
// entry, reads the map tile for each patch and fills removed entries with the last.
// One result word waits in the output register while the next command is taken.
// Depends on dtt_pkg and dtt_if.
module dirty_tile_tracker #(
  parameter int DIRTY_ENTRIES = dtt_pkg::DIRTY_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  dtt_in_if.sink                             item,
  dtt_out_if.source                          result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dtt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dtt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dtt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int IDX_W = (DIRTY_ENTRIES > 1) ? $clog2(DIRTY_ENTRIES) : 1;
  localparam int CNT_W = $clog2(DIRTY_ENTRIES + 1);
  localparam int ENT_W = dtt_pkg::COL_W + dtt_pkg::ROW_W + dtt_pkg::PEND_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DIRTY_ENTRIES);
  localparam logic [dtt_pkg::OFFS_W-1:0] LAST_CELL = dtt_pkg::OFFS_W'(dtt_pkg::MAP_DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_CMP,
    S_SRCH_CHK,
    S_MARK_ADD,
    S_MARK_EMIT,
    S_APL_CHK,
    S_APL_TILE,
    S_APL_PUSH,
    S_APL_MOVE,
    S_APL_FLUSH
  } state_t;

  typedef struct packed {
    logic                          changed;
    logic                          table_overflow;
    logic [dtt_pkg::OFFS_W-1:0]    map_offset;
    logic [dtt_pkg::CODE_W-1:0]    char_code;
    logic                          patch_valid;
    logic [dtt_pkg::COL_W-1:0]     patch_col;
    logic [dtt_pkg::ROW_W-1:0]     patch_row;
    logic                          last;
  } res_t;

  // Registers
  state_t                          state;
  logic [dtt_pkg::OFFS_W-1:0]      clr_addr;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                idx;
  logic [dtt_pkg::PATCH_CNT_W-1:0] npatch;
  logic [dtt_pkg::CODE_W-1:0]      char_base;
  logic [dtt_pkg::VCOLS_W-1:0]     view_cols;
  logic [dtt_pkg::VROWS_W-1:0]     view_rows;
  logic [dtt_pkg::COL_W-1:0]       x_q;
  logic [dtt_pkg::ROW_W-1:0]       y_q;
  logic [dtt_pkg::TILE_W-1:0]      tile_q;
  logic                            bsel_q;
  logic                            rebuild_q;
  logic [dtt_pkg::COL_W-1:0]       ox_q;
  logic [dtt_pkg::ROW_W-1:0]       oy_q;
  logic                            wrap_q;
  logic                            changed_q;
  logic                            ovf_q;
  logic [dtt_pkg::PEND_W-1:0]      pend_q;
  logic [dtt_pkg::COL_W-1:0]       pc_q;
  logic [dtt_pkg::ROW_W-1:0]       pr_q;
  logic [dtt_pkg::CODE_W-1:0]      pcode_q;
  res_t                            hold;
  logic                            hold_valid;
  res_t                            out;
  logic                            out_valid;

  // Memories
  logic [dtt_pkg::TILE_W-1:0]      map_mem [dtt_pkg::MAP_DEPTH];
  logic [dtt_pkg::TILE_W-1:0]      map_rdata;
  logic                            map_we;
  logic [dtt_pkg::OFFS_W-1:0]      map_waddr;
  logic [dtt_pkg::OFFS_W-1:0]      map_raddr;
  logic [dtt_pkg::TILE_W-1:0]      map_wdata;

  logic [ENT_W-1:0]                ent_mem [DIRTY_ENTRIES];
  logic [ENT_W-1:0]                ent_rdata;
  logic                            ent_we;
  logic [IDX_W-1:0]                ent_waddr;
  logic [IDX_W-1:0]                ent_raddr;
  logic [ENT_W-1:0]                ent_wdata;

  // Combinational
  logic                            item_acc;
  logic                            out_free;
  logic                            tile_diff;
  logic [dtt_pkg::COL_W-1:0]       ent_col;
  logic [dtt_pkg::ROW_W-1:0]       ent_row;
  logic [dtt_pkg::PEND_W-1:0]      ent_pend;
  logic                            ent_match;
  logic [dtt_pkg::PEND_W-1:0]      bmask;
  logic                            hit;
  logic [dtt_pkg::PEND_W-1:0]      pend_n;
  logic [dtt_pkg::COL_W-1:0]       col_d;
  logic [dtt_pkg::ROW_W-1:0]       row_d;
  logic                            col_in;
  logic                            row_in;
  logic                            emit;
  logic [dtt_pkg::PEND_W-1:0]      step_pend;
  logic [CNT_W-1:0]                idx_nx;
  logic [CNT_W-1:0]                cnt_dec;
  logic                            idx_last;
  logic [IDX_W-1:0]                step_raddr;
  res_t                            mark_res;
  res_t                            patch_res;
  res_t                            flush_res;
  logic                            cfg_we;
  logic [dtt_pkg::REG_IDX_W-1:0]   reg_idx;

  assign item_acc   = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign out_free   = !out_valid || result.ready;

  // Table entry fields, the view test, the map compare and the apply step addresses
  always_comb begin
    ent_col   = ent_rdata[ENT_W-1 -: dtt_pkg::COL_W];
    ent_row   = ent_rdata[dtt_pkg::PEND_W +: dtt_pkg::ROW_W];
    ent_pend  = ent_rdata[dtt_pkg::PEND_W-1:0];
    ent_match = (ent_col == x_q) && (ent_row == y_q);
    bmask     = bsel_q ? 2'b10 : 2'b01;
    hit       = |(ent_pend & bmask);
    pend_n    = ent_pend & ~bmask;
    // map sizes are powers of two, so a wrapped distance is the truncated difference
    col_d     = ent_col - ox_q;
    row_d     = ent_row - oy_q;
    col_in    = (wrap_q || (ent_col >= ox_q)) &&
                ({{(dtt_pkg::VCOLS_W - dtt_pkg::COL_W){1'b0}}, col_d} < view_cols);
    row_in    = (wrap_q || (ent_row >= oy_q)) &&
                ({{(dtt_pkg::VROWS_W - dtt_pkg::ROW_W){1'b0}}, row_d} < view_rows);
    emit      = hit && !rebuild_q && (npatch < dtt_pkg::MAX_PATCHES) && col_in && row_in;
    tile_diff = (map_rdata != tile_q);
    step_pend = (state == S_APL_CHK) ? pend_n : pend_q;
    idx_nx    = idx + 1'b1;
    cnt_dec   = count - 1'b1;
    idx_last  = (idx_nx == count);
    step_raddr = (step_pend == '0) ? cnt_dec[IDX_W-1:0] : idx_nx[IDX_W-1:0];
  end

  always_comb begin
    mark_res                = '0;
    mark_res.changed        = changed_q;
    mark_res.table_overflow = ovf_q;
    mark_res.map_offset     = {y_q, x_q};
    mark_res.char_code      = char_base + dtt_pkg::CODE_W'(tile_q);
    mark_res.last           = 1'b1;

    patch_res               = '0;
    patch_res.char_code     = pcode_q;
    patch_res.patch_valid   = 1'b1;
    patch_res.patch_col     = pc_q;
    patch_res.patch_row     = pr_q;

    flush_res               = hold;
    flush_res.last          = 1'b1;
  end

  // Map RAM controls
  always_comb begin
    map_we    = 1'b0;
    map_waddr = {y_q, x_q};
    map_wdata = tile_q;
    map_raddr = {y_q, x_q};
    case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = '0;
      end
      S_IDLE: begin
        map_raddr = {item.tile_y, item.tile_x};
        if (item_acc && (item.cmd == dtt_pkg::CMD_LOAD)) begin
          map_we    = 1'b1;
          map_waddr = {item.tile_y, item.tile_x};
          map_wdata = item.tile_value;
        end
      end
      S_MARK_CMP: map_we = tile_diff;
      S_APL_CHK:  map_raddr = {ent_row, ent_col};
      default: ;
    endcase
  end

  // Table RAM controls
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = idx[IDX_W-1:0];
    ent_wdata = {ent_col, ent_row, dtt_pkg::BOTH_BUFFERS};
    ent_raddr = idx[IDX_W-1:0];
    case (state)
      S_IDLE, S_MARK_CMP: ent_raddr = '0;
      S_SRCH_CHK: begin
        ent_raddr = idx_nx[IDX_W-1:0];
        ent_we    = ent_match;
      end
      S_MARK_ADD: begin
        ent_we    = (count < CNT_FULL);
        ent_waddr = count[IDX_W-1:0];
        ent_wdata = {x_q, y_q, dtt_pkg::BOTH_BUFFERS};
      end
      S_APL_CHK: begin
        ent_we    = (pend_n != '0);
        ent_wdata = {ent_col, ent_row, pend_n};
        ent_raddr = step_raddr;
      end
      S_APL_PUSH: ent_raddr = step_raddr;
      S_APL_MOVE: begin
        // copy the last entry into the hole and read it again for the next check
        ent_we    = (idx != count);
        ent_wdata = ent_rdata;
        ent_raddr = count[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata <= ent_mem[ent_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      count      <= '0;
      idx        <= '0;
      npatch     <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_acc) begin
            x_q       <= item.tile_x;
            y_q       <= item.tile_y;
            tile_q    <= item.tile_value;
            bsel_q    <= item.buffer_sel;
            rebuild_q <= item.full_rebuild;
            ox_q      <= item.view_origin_x;
            oy_q      <= item.view_origin_y;
            wrap_q    <= item.wrap_mode;
            idx       <= '0;
            npatch    <= '0;
            case (item.cmd)
              dtt_pkg::CMD_MARK:  state <= S_MARK_CMP;
              dtt_pkg::CMD_APPLY: state <= (count == '0) ? S_IDLE : S_APL_CHK;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_MARK_CMP: begin
          changed_q <= tile_diff;
          ovf_q     <= 1'b0;
          if (!tile_diff) begin
            state <= S_MARK_EMIT;
          end else if (count == '0) begin
            state <= S_MARK_ADD;
          end else begin
            state <= S_SRCH_CHK;
          end
        end
        S_SRCH_CHK: begin
          if (ent_match) begin
            state <= S_MARK_EMIT;
          end else if (idx_last) begin
            state <= S_MARK_ADD;
          end else begin
            idx <= idx_nx;
          end
        end
        S_MARK_ADD: begin
          if (count < CNT_FULL) begin
            count <= count + 1'b1;
          end else begin
            // full table: drop everything and ask for a full redraw
            count <= '0;
            ovf_q <= 1'b1;
          end
          state <= S_MARK_EMIT;
        end
        S_MARK_EMIT: begin
          if (out_free) begin
            out       <= mark_res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_APL_CHK: begin
          pend_q <= pend_n;
          pc_q   <= col_d;
          pr_q   <= row_d;
          if (emit) begin
            state <= S_APL_TILE;
          end else if (step_pend == '0) begin
            count <= cnt_dec;
            state <= S_APL_MOVE;
          end else if (idx_last) begin
            state <= S_APL_FLUSH;
          end else begin
            idx   <= idx_nx;
            state <= S_APL_CHK;
          end
        end
        S_APL_TILE: begin
          pcode_q <= char_base + dtt_pkg::CODE_W'(map_rdata);
          state   <= S_APL_PUSH;
        end
        S_APL_PUSH: begin
          // keep one patch back so the final one can carry last
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              out       <= hold;
              out_valid <= 1'b1;
            end
            hold       <= patch_res;
            hold_valid <= 1'b1;
            npatch     <= npatch + 1'b1;
            if (step_pend == '0) begin
              count <= cnt_dec;
              state <= S_APL_MOVE;
            end else if (idx_last) begin
              state <= S_APL_FLUSH;
            end else begin
              idx   <= idx_nx;
              state <= S_APL_CHK;
            end
          end
        end
        S_APL_MOVE: begin
          state <= (idx == count) ? S_APL_FLUSH : S_APL_CHK;
        end
        S_APL_FLUSH: begin
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out        <= flush_res;
            out_valid  <= 1'b1;
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Register port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[dtt_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      char_base <= dtt_pkg::CHAR_BASE_RST;
      view_cols <= dtt_pkg::VIEW_COLS_RST;
      view_rows <= dtt_pkg::VIEW_ROWS_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        dtt_pkg::REG_CHAR_BASE: char_base <= pwdata[dtt_pkg::CODE_W-1:0];
        dtt_pkg::REG_VIEW_COLS: view_cols <= pwdata[dtt_pkg::VCOLS_W-1:0];
        dtt_pkg::REG_VIEW_ROWS: view_rows <= pwdata[dtt_pkg::VROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dtt_pkg::REG_CHAR_BASE: prdata = dtt_pkg::CFG_DATA_W'(char_base);
      dtt_pkg::REG_VIEW_COLS: prdata = dtt_pkg::CFG_DATA_W'(view_cols);
      dtt_pkg::REG_VIEW_ROWS: prdata = dtt_pkg::CFG_DATA_W'(view_rows);
      default:                prdata = '0;
    endcase
  end

  // Result channel
  assign result.valid          = out_valid;
  assign result.changed        = out.changed;
  assign result.table_overflow = out.table_overflow;
  assign result.map_offset     = out.map_offset;
  assign result.char_code      = out.char_code;
  assign result.patch_valid    = out.patch_valid;
  assign result.patch_col      = out.patch_col;
  assign result.patch_row      = out.patch_row;
  assign result.last           = out.last;

endmodule

// ----- design/dtt_checker.sv -----
// Port-level checks for the dirty tile tracker, bound to the top level.
// Depends on dtt_pkg and dirty_tile_tracker_assert.svh.
`include "dirty_tile_tracker_assert.svh"

module dtt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic [dtt_pkg::CMD_W-1:0]     item_cmd,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic                          result_changed,
  input logic                          result_table_overflow,
  input logic [dtt_pkg::OFFS_W-1:0]    result_map_offset,
  input logic                          result_patch_valid,
  input logic [dtt_pkg::COL_W-1:0]     result_patch_col,
  input logic [dtt_pkg::ROW_W-1:0]     result_patch_row,
  input logic                          result_last
);

  // a stalled result word stays offered
  `DTT_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result word dropped while stalled")

  // a mark always takes the sequencer away, so ready drops after the accept
  `DTT_ASSERT_NEXT(a_mark_busy, item_valid && item_ready && (item_cmd == dtt_pkg::CMD_MARK), !item_ready, "ready after mark accept")

  `DTT_ASSERT_NOW(a_mark_word, result_valid && !result_patch_valid, result_last && (result_patch_col == '0) && (result_patch_row == '0), "bad mark word")

  `DTT_ASSERT_NOW(a_patch_word, result_valid && result_patch_valid, !result_changed && !result_table_overflow && (result_map_offset == '0), "bad patch word")

endmodule

bind dirty_tile_tracker dtt_checker u_dtt_checker (
  .clk                   (clk),
  .rst                   (rst),
  .item_valid            (item.valid),
  .item_ready            (item.ready),
  .item_cmd              (item.cmd),
  .result_valid          (result.valid),
  .result_ready          (result.ready),
  .result_changed        (result.changed),
  .result_table_overflow (result.table_overflow),
  .result_map_offset     (result.map_offset),
  .result_patch_valid    (result.patch_valid),
  .result_patch_col      (result.patch_col),
  .result_patch_row      (result.patch_row),
  .result_last           (result.last)
);
